FILE: design/assert_macros.svh
// Assertion helpers shared by the walker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

FILE: design/flptw_pkg.sv
// ----------------------------------------------------------------------------
// flptw_pkg
// Types, codes and constants of the four-level page-table walker.
// ----------------------------------------------------------------------------
package flptw_pkg;
	localparam int PAGE_COUNT_BITS_DEF = 16;
	localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;

	localparam logic [1:0] OP_TRANSLATE = 2'd0;
	localparam logic [1:0] OP_PROTECT   = 2'd1;
	localparam logic [1:0] OP_UNMAP     = 2'd2;
	localparam logic [1:0] OP_DATA      = 2'd3;

	localparam logic [2:0] KIND_READ  = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_FREED = 3'd2;
	localparam logic [2:0] KIND_SHOOT = 3'd3;
	localparam logic [2:0] KIND_DONE  = 3'd4;

	localparam logic [1:0] REG_ROOT  = 2'd0;
	localparam logic [1:0] REG_VALID = 2'd1;
	localparam logic [1:0] REG_SLOT  = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [51:0] mem_address;
		logic [63:0] write_data;
		logic [51:0] freed_frame;
		logic [51:0] phys_address;
		logic [63:0] entry_flags;
		logic        success;
		logic        last;
	} result_t;

	function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] lvl);
		logic [8:0] r;
		case (lvl)
			2'd0: r = va[47:39];
			2'd1: r = va[38:30];
			2'd2: r = va[29:21];
			default: r = va[20:12];
		endcase
		return r;
	endfunction
endpackage

FILE: design/flptw_engine.sv
// ----------------------------------------------------------------------------
// flptw_engine
// Front part: takes commands and read data, updates the walk state and writes
// the results each item causes (up to four) into the result queue.
// ----------------------------------------------------------------------------
module flptw_engine #(
	parameter int PAGE_COUNT_BITS = flptw_pkg::PAGE_COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_fire,
	input  logic [1:0]               operation,
	input  logic [47:0]              vaddr,
	input  logic [PAGE_COUNT_BITS-1:0] page_count,
	input  logic [11:0]              new_flags,
	input  logic                     no_execute,
	input  logic [63:0]              read_data,
	input  logic [51:0]              root_address,
	input  logic                     root_valid,
	input  logic [8:0]               user_slot,
	output logic [2:0]               push_n,
	output flptw_pkg::result_t       push_r [4]
);
	import flptw_pkg::*;

	logic        busy_q;
	logic [1:0]  cmd_q;
	logic [1:0]  level_q;
	logic [47:0] cur_q;
	logic [8:0]  start_slot_q;
	logic [PAGE_COUNT_BITS-1:0] left_q;
	logic [12:0] flags_q;
	logic [51:0] leaf_q;

	result_t     r [4];
	logic [2:0]  n;
	logic [51:0] frame;
	logic [51:0] root_rd;
	logic        rej;
	logic        more;

	assign frame   = read_data[51:0] & ADDR_MASK[51:0];
	assign root_rd = root_address + {40'd0, level_index(vaddr, 2'd0), 3'b000};
	assign rej     = !root_valid || (operation != OP_TRANSLATE &&
		(page_count == '0 || vaddr[11:0] != 12'd0));
	assign more    = left_q != PAGE_COUNT_BITS'(1);

	always_comb begin
		r = '{default: '0};
		n = 3'd0;
		if (in_fire) begin
			if (operation != OP_DATA) begin
				if (!busy_q) begin
					n = 3'd1;
					if (rej) begin
						r[0].kind = KIND_DONE;
					end else begin
						r[0].kind = KIND_READ;
						r[0].mem_address = root_rd;
					end
				end
			end else if (busy_q) begin
				n = 3'd1;
				if (read_data == 64'd0) begin
					r[0].kind = KIND_DONE;
				end else if (level_q != 2'd3) begin
					r[0].kind = KIND_READ;
					r[0].mem_address = frame +
						{40'd0, level_index(cur_q, level_q + 2'd1), 3'b000};
				end else if (cmd_q == OP_TRANSLATE) begin
					r[0].kind = KIND_DONE;
					r[0].success = 1'b1;
					r[0].phys_address = frame | {40'd0, cur_q[11:0]};
					r[0].entry_flags = read_data & ~ADDR_MASK;
				end else begin
					r[0].kind = KIND_WRITE;
					r[0].mem_address = leaf_q;
					if (cmd_q == OP_PROTECT) begin
						r[0].write_data = {flags_q[12], 11'd0, frame} |
							{52'd0, flags_q[11:0]} | 64'd1;
					end else begin
						r[1].kind = KIND_FREED;
						r[1].freed_frame = frame;
						n = 3'd2;
					end
					if (more) begin
						r[n[1:0]].kind = KIND_READ;
						r[n[1:0]].mem_address = root_address + {40'd0,
							level_index(cur_q + 48'h1000, 2'd0), 3'b000};
						n = n + 3'd1;
					end else begin
						if (root_valid && root_address != 52'd0 && start_slot_q == user_slot) begin
							r[n[1:0]].kind = KIND_SHOOT;
							n = n + 3'd1;
						end
						r[n[1:0]].kind = KIND_DONE;
						r[n[1:0]].success = 1'b1;
						n = n + 3'd1;
					end
				end
			end
			if (n != 3'd0) r[n[1:0] - 2'd1].last = 1'b1;
		end
	end

	assign push_n = n;
	assign push_r = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; cmd_q <= OP_DATA; level_q <= 2'd0; cur_q <= '0;
			start_slot_q <= '0; left_q <= '0; flags_q <= '0; leaf_q <= '0;
		end else if (in_fire) begin
			if (operation != OP_DATA) begin
				if (!busy_q && !rej) begin
					busy_q <= 1'b1; cmd_q <= operation; level_q <= 2'd0;
					cur_q <= vaddr; start_slot_q <= vaddr[47:39];
					left_q <= page_count; flags_q <= {no_execute, new_flags};
					leaf_q <= root_rd;
				end
			end else if (busy_q) begin
				if (read_data == 64'd0) begin
					busy_q <= 1'b0;
				end else if (level_q != 2'd3) begin
					level_q <= level_q + 2'd1;
					leaf_q <= r[0].mem_address;
				end else if (cmd_q == OP_TRANSLATE) begin
					busy_q <= 1'b0;
				end else begin
					left_q <= left_q - PAGE_COUNT_BITS'(1);
					if (more) begin
						cur_q <= cur_q + 48'h1000;
						level_q <= 2'd0;
						leaf_q <= r[n[1:0] - 2'd1].mem_address;
					end else begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	`include "assert_macros.svh"
	`ASSERT_ALWAYS(a_push_bound, clk, arst_n, push_n <= 3'd4, "too many results")
	`ASSERT_IMP(a_start_level, clk, arst_n, $rose(busy_q), level_q == 2'd0,
		"walk started below the top level")
endmodule

FILE: design/flptw_queue.sv
// ----------------------------------------------------------------------------
// flptw_queue
// Back part: result queue taking up to four entries a cycle, popping one.
// ----------------------------------------------------------------------------
module flptw_queue #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         push_n,
	input  flptw_pkg::result_t push_r [4],
	output logic               space,
	output logic               out_valid,
	output flptw_pkg::result_t out_r,
	input  logic               pop
);
	import flptw_pkg::*;
	localparam int AW = $clog2(DEPTH);

	result_t        mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;

	// Room for a worst-case item of four results, not counting this cycle's pop.
	assign space     = cnt_q <= (AW+1)'(DEPTH - 4);
	assign out_valid = cnt_q != '0;
	assign out_r     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++)
			if (3'(i) < push_n) mem_q[wp_q + AW'(i)] <= push_r[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(push_n);
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + (AW+1)'(push_n) - (AW+1)'(pop);
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMP(a_no_overflow, clk, arst_n, push_n != 3'd0, space, "push without room")
	`ASSERT_IMP(a_no_underflow, clk, arst_n, pop, out_valid, "pop from empty queue")
endmodule

FILE: design/four_level_page_table_walker.sv
// Results: an input's results are registered in the result queue and offered from its head in order.
// Throughput: one input per cycle while the result queue holds twelve or fewer
// entries; results leave at one per cycle while out_stall is low, so unmap leaves are output bound.
// Reset: arst_n clears the walk state, the queue and the registers at once.
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Walks four-level page tables, issuing entry reads and writes, freed frames, shootdowns and completions as results.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
	parameter int PAGE_COUNT_BITS = flptw_pkg::PAGE_COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [51:0]                cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [47:0]                vaddr,
	input  logic [PAGE_COUNT_BITS-1:0] page_count,
	input  logic [11:0]                new_flags,
	input  logic                       no_execute,
	input  logic [63:0]                read_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 kind,
	output logic [51:0]                mem_address,
	output logic [63:0]                write_data,
	output logic [51:0]                freed_frame,
	output logic [51:0]                phys_address,
	output logic [63:0]                entry_flags,
	output logic                       success,
	output logic                       last
);
	import flptw_pkg::*;

	logic [51:0] root_q;
	logic        rvalid_q;
	logic [8:0]  slot_q;
	logic        space, in_fire;
	logic [2:0]  push_n;
	result_t     push_r [4];
	result_t     out_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0; rvalid_q <= 1'b0; slot_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROOT:  root_q <= cfg_data;
				REG_VALID: rvalid_q <= cfg_data[0];
				REG_SLOT:  slot_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign in_stall = !space;
	assign in_fire  = in_valid && space;

	flptw_engine #(.PAGE_COUNT_BITS(PAGE_COUNT_BITS)) u_engine (
		.clk, .arst_n, .in_fire, .operation, .vaddr, .page_count,
		.new_flags, .no_execute, .read_data, .root_address(root_q),
		.root_valid(rvalid_q), .user_slot(slot_q), .push_n, .push_r
	);

	flptw_queue u_queue (
		.clk, .arst_n, .push_n, .push_r, .space, .out_valid, .out_r,
		.pop(out_valid && !out_stall)
	);

	assign kind         = out_r.kind;
	assign mem_address  = out_r.mem_address;
	assign write_data   = out_r.write_data;
	assign freed_frame  = out_r.freed_frame;
	assign phys_address = out_r.phys_address;
	assign entry_flags  = out_r.entry_flags;
	assign success      = out_r.success;
	assign last         = out_r.last;
endmodule
